/* src/sust_pkg.sv */
// ----------------------------------------------------------------------------
// sust_pkg: shared types and constants of the sorted score table
// Transaction structs, operation and status codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package sust_pkg;

    localparam int CAPACITY   = 16;
    localparam int SCORE_BITS = 16;
    // address of one entry, and a count or walk index that can reach CAPACITY
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_POP    = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_INSERTED  = 4'd0,
        ST_DUPLICATE = 4'd1,
        ST_EVICTED   = 4'd2,
        ST_DROPPED   = 4'd3,
        ST_REMOVED   = 4'd4,
        ST_NOTFOUND  = 4'd5,
        ST_READ      = 4'd6,
        ST_BADRANK   = 4'd7,
        ST_POPPED    = 4'd8,
        ST_EMPTY     = 4'd9
    } t_status;

    typedef struct packed {
        t_op         operation;
        logic [15:0] score_value;
        logic [3:0]  rank;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [15:0] result_value;
        logic [4:0]  entry_count;
        logic        is_empty;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_FIND,
        S_INS_SHIFT,
        S_REM_FIND,
        S_REM_SHIFT,
        S_POP,
        S_READ
    } t_state;

    typedef enum logic [1:0] {
        WD_SCORE,
        WD_CARRY,
        WD_RDATA
    } t_wsel;

    typedef enum logic [1:0] {
        VS_ZERO,
        VS_RDATA,
        VS_CARRY
    } t_vsel;

    typedef struct packed {
        logic    accept;
        logic    idx_inc;
        logic    wr_en;
        logic    wr_prev;
        t_wsel   wsel;
        logic    carry_load;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    finish;
        t_status status;
        t_vsel   vsel;
    } t_dp_cmd;

    typedef struct packed {
        logic at_end;
        logic gt;
        logic eq;
        logic full;
        logic empty;
        logic rank_ok;
    } t_dp_stat;

endpackage

/* src/sust_ctrl.sv */
// ----------------------------------------------------------------------------
// sust_ctrl: operation sequencer
// Walks the table one entry per cycle and tells the datapath what to move,
// when to finish and with which status.
// ----------------------------------------------------------------------------
module sust_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sust_pkg::t_op     i_op,
    input  sust_pkg::t_dp_stat i_stat,
    output sust_pkg::t_dp_cmd o_cmd,
    output logic              o_busy
);
    import sust_pkg::*;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_INSERT;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '{accept: 1'b0, idx_inc: 1'b0, wr_en: 1'b0, wr_prev: 1'b0,
                    wsel: WD_SCORE, carry_load: 1'b0, cnt_inc: 1'b0,
                    cnt_dec: 1'b0, finish: 1'b0, status: ST_INSERTED,
                    vsel: VS_ZERO};
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_op         = i_op;
                    case (i_op)
                        OP_INSERT: n_state = S_INS_FIND;
                        OP_REMOVE: n_state = S_REM_FIND;
                        OP_READ:   n_state = S_READ;
                        OP_POP:    n_state = S_POP;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_FIND: begin
                if (i_stat.at_end) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                    if (i_stat.full) begin
                        o_cmd.status = ST_DROPPED;
                    end else begin
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                        o_cmd.status  = ST_INSERTED;
                    end
                end else if (i_stat.gt) begin
                    o_cmd.idx_inc = 1'b1;
                end else if (i_stat.eq) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_DUPLICATE;
                    n_state      = S_IDLE;
                end else begin
                    // new score goes here, the old entry rides down in carry
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.carry_load = 1'b1;
                    o_cmd.idx_inc    = 1'b1;
                    n_state          = S_INS_SHIFT;
                end
            end
            S_INS_SHIFT: begin
                if (i_stat.at_end) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                    if (i_stat.full) begin
                        o_cmd.status = ST_EVICTED;
                        o_cmd.vsel   = VS_CARRY;
                    end else begin
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.wsel    = WD_CARRY;
                        o_cmd.cnt_inc = 1'b1;
                        o_cmd.status  = ST_INSERTED;
                    end
                end else begin
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.wsel       = WD_CARRY;
                    o_cmd.carry_load = 1'b1;
                    o_cmd.idx_inc    = 1'b1;
                end
            end
            S_REM_FIND: begin
                if (i_stat.at_end || (!i_stat.gt && !i_stat.eq)) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_NOTFOUND;
                    n_state      = S_IDLE;
                end else if (i_stat.eq) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_REM_SHIFT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_POP: begin
                if (i_stat.empty) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_EMPTY;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.carry_load = 1'b1;
                    o_cmd.idx_inc    = 1'b1;
                    n_state          = S_REM_SHIFT;
                end
            end
            S_REM_SHIFT: begin
                if (i_stat.at_end) begin
                    o_cmd.finish  = 1'b1;
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_IDLE;
                    if (r_op == OP_POP) begin
                        o_cmd.status = ST_POPPED;
                        o_cmd.vsel   = VS_CARRY;
                    end else begin
                        o_cmd.status = ST_REMOVED;
                    end
                end else begin
                    // close the gap: entry moves up one rank
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_prev = 1'b1;
                    o_cmd.wsel    = WD_RDATA;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
                if (i_stat.rank_ok) begin
                    o_cmd.status = ST_READ;
                    o_cmd.vsel   = VS_RDATA;
                end else begin
                    o_cmd.status = ST_BADRANK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* src/sust_dp.sv */
// ----------------------------------------------------------------------------
// sust_dp: score table datapath
// Score memory with registered read, walk index, carry register, entry count
// and the result register.
// ----------------------------------------------------------------------------
module sust_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sust_pkg::t_in      i_cmd_in,
    input  sust_pkg::t_dp_cmd  i_cmd,
    output sust_pkg::t_dp_stat o_stat,
    output logic               o_valid,
    output sust_pkg::t_out     o_result
);
    import sust_pkg::*;

    logic [SCORE_BITS-1:0] mem [CAPACITY];

    logic [SCORE_BITS-1:0] r_score, r_carry, r_rdata;
    logic [CW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_rank_ok;
    logic                  r_valid;
    t_out                  r_result;

    logic [CW-1:0]         wr_idx;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic [SCORE_BITS-1:0] wdata, value;

    // read address runs one step ahead so r_rdata holds the entry at r_idx
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.accept) begin
            if (i_cmd_in.operation == OP_READ) begin
                n_idx = CW'(i_cmd_in.rank);
            end else begin
                n_idx = '0;
            end
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + CW'(1);
        end
    end

    assign rd_addr = n_idx[AW-1:0];
    assign wr_idx  = i_cmd.wr_prev ? (r_idx - CW'(1)) : r_idx;
    assign wr_addr = wr_idx[AW-1:0];

    always_comb begin
        case (i_cmd.wsel)
            WD_SCORE: wdata = r_score;
            WD_CARRY: wdata = r_carry;
            WD_RDATA: wdata = r_rdata;
            default:  wdata = r_score;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr] <= wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        case (i_cmd.vsel)
            VS_ZERO:  value = '0;
            VS_RDATA: value = r_rdata;
            VS_CARRY: value = r_carry;
            default:  value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_count <= n_count;
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_score   <= SCORE_BITS'(i_cmd_in.score_value);
            r_rank_ok <= (32'(i_cmd_in.rank) < 32'(r_count));
        end
        if (i_cmd.carry_load) begin
            r_carry <= r_rdata;
        end
        if (i_cmd.finish) begin
            r_result.status       <= i_cmd.status;
            r_result.result_value <= 16'(value);
            r_result.entry_count  <= 5'(n_count);
            r_result.is_empty     <= (n_count == '0);
        end
    end

    assign o_stat.at_end  = (r_idx == r_count);
    assign o_stat.gt      = (r_rdata > r_score);
    assign o_stat.eq      = (r_rdata == r_score);
    assign o_stat.full    = (r_count == CW'(CAPACITY));
    assign o_stat.empty   = (r_count == '0);
    assign o_stat.rank_ok = r_rank_ok;

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* src/sorted_unique_score_table.sv */
// ----------------------------------------------------------------------------
// sorted_unique_score_table: bounded table of distinct scores, highest first
// Insert, remove, read at rank and pop over a score memory with separate write and read ports.
// ----------------------------------------------------------------------------
// One transaction at a time: raise start while busy is low and the command is
// taken at that edge. The table is walked one entry per clock through a memory
// with one write and one registered read port; insert, remove and pop walk the
// stored entries, and a read looks up one rank. o_valid is high for exactly
// one cycle with the result on o_result and cannot be held off; busy is
// already low in that cycle, so the next command may be issued then. Table
// state after reset is empty.
module sorted_unique_score_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  sust_pkg::t_in  i_cmd,
    output logic           o_valid,
    output sust_pkg::t_out o_result
);
    import sust_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    sust_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_cmd.operation),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    sust_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_in (i_cmd),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

/* src/sust_checker.sv */
// ----------------------------------------------------------------------------
// sust_checker: port-level checks of the score table
// Watches handshake and result consistency; bound to the top level.
// ----------------------------------------------------------------------------
module sust_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input sust_pkg::t_in  i_cmd,
    input logic           o_valid,
    input sust_pkg::t_out o_result
);
    import sust_pkg::*;

    // an accepted transaction always raises busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // a result closes the transaction that was in flight
    a_valid_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("result without a transaction in flight");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.is_empty == (o_result.entry_count == 5'd0))
                 && (32'(o_result.entry_count) <= CAPACITY))
        else $error("entry count and empty flag disagree");

    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.result_value != 16'd0) |->
            (o_result.status == ST_READ) || (o_result.status == ST_EVICTED)
            || (o_result.status == ST_POPPED))
        else $error("nonzero value on a status that carries none");

    a_op_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd.operation == OP_READ) ##2 1 |->
            o_valid && ((o_result.status == ST_READ)
                        || (o_result.status == ST_BADRANK)))
        else $error("read did not answer in two cycles");

endmodule

bind sorted_unique_score_table sust_checker u_sust_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_valid  (o_valid),
    .o_result (o_result)
);

/* tb/sorted_unique_score_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_score_table_tb: self-checking bench for the sorted score table
// Drives insert, remove, read and pop commands through the start/busy handshake
// and mirrors the table in a scoreboard. Each result is compared field by field
// with the oldest expected one. A directed opening covers the empty table, the
// full table, duplicates, drops, evictions and bad ranks. Random fill, mix and
// drain runs follow under three sender idle settings.
// ----------------------------------------------------------------------------

class score_table_board;
    logic [15:0] ranked [sust_pkg::CAPACITY];
    int unsigned held = 0;
    sust_pkg::t_out awaited_results[$];
    int errors = 0;
    int checked = 0;
    bit [15:0] seen_status = '0;

    function void drop_entry(input int unsigned pos);
        int unsigned i;
        for (i = pos; i + 1 < held; i++) ranked[i] = ranked[i + 1];
        held--;
    endfunction

    // applies one command to the mirrored table and returns its outcome
    function sust_pkg::t_out table_outcome(input sust_pkg::t_in c);
        sust_pkg::t_out r;
        int unsigned pos;
        int unsigned i;
        logic [15:0] s;
        r = '0;
        s = c.score_value;
        pos = 0;
        case (c.operation)
            sust_pkg::OP_INSERT: begin
                while (pos < held && ranked[pos] > s) pos++;
                if (pos < held && ranked[pos] == s) begin
                    r.status = sust_pkg::ST_DUPLICATE;
                end else if (held >= sust_pkg::CAPACITY && pos >= held) begin
                    r.status = sust_pkg::ST_DROPPED;
                end else begin
                    r.status = sust_pkg::ST_INSERTED;
                    if (held >= sust_pkg::CAPACITY) begin
                        r.result_value = ranked[held - 1];
                        r.status = sust_pkg::ST_EVICTED;
                        held--;
                    end
                    for (i = held; i > pos; i--) ranked[i] = ranked[i - 1];
                    ranked[pos] = s;
                    held++;
                end
            end
            sust_pkg::OP_REMOVE: begin
                while (pos < held && ranked[pos] > s) pos++;
                if (pos < held && ranked[pos] == s) begin
                    drop_entry(pos);
                    r.status = sust_pkg::ST_REMOVED;
                end else begin
                    r.status = sust_pkg::ST_NOTFOUND;
                end
            end
            sust_pkg::OP_READ: begin
                if (c.rank < held) begin
                    r.result_value = ranked[c.rank];
                    r.status = sust_pkg::ST_READ;
                end else begin
                    r.status = sust_pkg::ST_BADRANK;
                end
            end
            default: begin
                if (held == 0) begin
                    r.status = sust_pkg::ST_EMPTY;
                end else begin
                    r.result_value = ranked[0];
                    drop_entry(0);
                    r.status = sust_pkg::ST_POPPED;
                end
            end
        endcase
        r.entry_count = 5'(held);
        r.is_empty = (held == 0);
        return r;
    endfunction

    function void log_command(input sust_pkg::t_in c);
        awaited_results.push_back(table_outcome(c));
    endfunction

    function void check_result(input sust_pkg::t_out got);
        sust_pkg::t_out exp;
        if (awaited_results.size() == 0) begin
            $error("result with no command outstanding: status %0d value %0d",
                   got.status, got.result_value);
            errors++;
            return;
        end
        exp = awaited_results.pop_front();
        checked++;
        if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            errors++;
        end else begin
            seen_status[exp.status] = 1'b1;
        end
        if (got.result_value !== exp.result_value) begin
            $error("result_value: expected %0d, got %0d", exp.result_value, got.result_value);
            errors++;
        end
        if (got.entry_count !== exp.entry_count) begin
            $error("entry_count: expected %0d, got %0d", exp.entry_count, got.entry_count);
            errors++;
        end
        if (got.is_empty !== exp.is_empty) begin
            $error("is_empty: expected %0d, got %0d", exp.is_empty, got.is_empty);
            errors++;
        end
    endfunction
endclass

module sorted_unique_score_table_tb;
    import sust_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  cmd;
    logic o_valid;
    t_out o_result;

    score_table_board board = new();
    int unsigned idle_pct;
    int issued;

    sorted_unique_score_table uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (cmd),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) board.check_result(o_result);
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic issue(input t_in c);
        while ($urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        cmd = c;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.log_command(c);
        issued++;
        @(negedge i_clk);
    endtask

    function automatic t_in make_cmd(input t_op op, input logic [15:0] score,
                                     input logic [3:0] rank);
        t_in c;
        c.operation = op;
        c.score_value = score;
        c.rank = rank;
        return c;
    endfunction

    // weights in percent; pop takes whatever is left
    function automatic t_in pick_command(input int unsigned ins_pct,
                                         input int unsigned rem_pct,
                                         input int unsigned rd_pct);
        t_in c;
        int unsigned r;
        int unsigned n;
        logic [15:0] lo;
        n = board.held;
        c.score_value = 16'($urandom_range(0, 65535));
        c.rank = 4'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < ins_pct) begin
            c.operation = OP_INSERT;
            r = $urandom_range(0, 99);
            if (n > 0 && r < 20) begin
                c.score_value = board.ranked[$urandom_range(0, n - 1)];
            end else if (n >= CAPACITY && r < 45) begin
                // aim below the lowest entry so the new score is dropped
                lo = board.ranked[n - 1];
                if (lo > 0) c.score_value = 16'($urandom_range(0, lo - 1));
            end else if (r < 50) begin
                c.score_value = r[0] ? 16'hFFFF : 16'h0000;
            end
        end else if (r < ins_pct + rem_pct) begin
            c.operation = OP_REMOVE;
            if (n > 0 && $urandom_range(0, 99) < 65)
                c.score_value = board.ranked[$urandom_range(0, n - 1)];
        end else if (r < ins_pct + rem_pct + rd_pct) begin
            c.operation = OP_READ;
            if (n > 0 && $urandom_range(0, 99) < 75) c.rank = 4'($urandom_range(0, n - 1));
        end else begin
            c.operation = OP_POP;
        end
        return c;
    endfunction

    initial begin
        int k;
        int ph;
        i_rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        idle_pct = 0;
        issued = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table corner cases
        issue(make_cmd(OP_POP, 16'hFFFF, 4'hF));
        issue(make_cmd(OP_READ, 16'h0000, 4'h0));
        issue(make_cmd(OP_REMOVE, 16'h1234, 4'h0));
        // fill to capacity, highest first then ascending inserts shifting the tail
        issue(make_cmd(OP_INSERT, 16'hFFFF, 4'h0));
        for (k = 0; k < 15; k++) issue(make_cmd(OP_INSERT, 16'(k * 4097 + 1), 4'hF));
        // full table: new lowest dropped, duplicate, insert that evicts the lowest
        issue(make_cmd(OP_INSERT, 16'h0000, 4'h0));
        issue(make_cmd(OP_INSERT, 16'hFFFF, 4'h0));
        issue(make_cmd(OP_INSERT, 16'd30000, 4'h0));
        issue(make_cmd(OP_READ, 16'hFFFF, 4'hF));
        issue(make_cmd(OP_REMOVE, 16'd4098, 4'h5));
        issue(make_cmd(OP_POP, 16'h0000, 4'h0));

        for (ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 16 : (ph == 1) ? 80 : 0;
            for (k = 0; k < 133; k++) begin
                if (k < 50) issue(pick_command(70, 10, 10));
                else if (k < 90) issue(pick_command(35, 25, 25));
                else issue(pick_command(10, 35, 20));
            end
        end
        start = 1'b0;

        while (board.awaited_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("summary: %0d commands issued, %0d results checked, %0d of 10 status codes seen",
                 issued, board.checked, $countones(board.seen_status));
        $display("summary: fill, mixed and drain runs with sender idle at 16, 80 and 0 percent");
        if (board.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
src/sust_pkg.sv
src/sust_ctrl.sv
src/sust_dp.sv
src/sorted_unique_score_table.sv
src/sust_checker.sv
tb/sorted_unique_score_table_tb.sv
